// ===== src/vnet_mmio_pkg.sv =====
// ----------------------------------------------------------------------------
// vnet_mmio_pkg
// Register offsets, operation codes, identity words and the result word type
// of the virtio-mmio network device register block.
// ----------------------------------------------------------------------------
package vnet_mmio_pkg;

    // Operation codes carried in the slave tuser
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_USED  = 2'd2;

    // Widths of the bus fields
    localparam int OFFSET_W   = 12;
    localparam int DATA_W     = 32;
    localparam int MAC_W      = 48;
    localparam int IN_TDATA_W  = 48;   // offset + write data, padded to bytes
    localparam int OUT_TDATA_W = 40;   // read data + two flags, padded to bytes

    // Register map (byte offsets)
    localparam logic [11:0] REG_MAGIC          = 12'h000;
    localparam logic [11:0] REG_VERSION        = 12'h004;
    localparam logic [11:0] REG_DEVICE_ID      = 12'h008;
    localparam logic [11:0] REG_VENDOR_ID      = 12'h00c;
    localparam logic [11:0] REG_DEV_FEATURES   = 12'h010;
    localparam logic [11:0] REG_DEV_FEAT_SEL   = 12'h014;
    localparam logic [11:0] REG_DRV_FEATURES   = 12'h020;
    localparam logic [11:0] REG_DRV_FEAT_SEL   = 12'h024;
    localparam logic [11:0] REG_QUEUE_SEL      = 12'h030;
    localparam logic [11:0] REG_QUEUE_NUM_MAX  = 12'h034;
    localparam logic [11:0] REG_QUEUE_NUM      = 12'h038;
    localparam logic [11:0] REG_QUEUE_READY    = 12'h044;
    localparam logic [11:0] REG_QUEUE_NOTIFY   = 12'h050;
    localparam logic [11:0] REG_INT_STATUS     = 12'h060;
    localparam logic [11:0] REG_INT_ACK        = 12'h064;
    localparam logic [11:0] REG_STATUS         = 12'h070;
    localparam logic [11:0] REG_DESC_LOW       = 12'h080;
    localparam logic [11:0] REG_DESC_HIGH      = 12'h084;
    localparam logic [11:0] REG_AVAIL_LOW      = 12'h090;
    localparam logic [11:0] REG_AVAIL_HIGH     = 12'h094;
    localparam logic [11:0] REG_USED_LOW       = 12'h0a0;
    localparam logic [11:0] REG_USED_HIGH      = 12'h0a4;
    localparam logic [11:0] REG_CFG_MAC_FIRST  = 12'h100;
    localparam logic [11:0] REG_CFG_MAC_END    = 12'h106;

    // Identity and feature words
    localparam logic [31:0] MAGIC_VALUE     = 32'h74726976;
    localparam logic [31:0] VERSION_VALUE   = 32'd2;
    localparam logic [31:0] DEVICE_ID_NET   = 32'd1;
    localparam logic [31:0] VENDOR_VALUE    = 32'h52564531;
    localparam logic [31:0] FEAT_WORD0      = 32'h0000_0020;  // MAC feature
    localparam logic [31:0] FEAT_WORD1      = 32'h0000_0001;  // VERSION_1

    localparam int STATUS_DRV_OK_BIT = 2;

    localparam logic [47:0] MAC_RESET = 48'h5634_1200_5452;

    // One result word
    typedef struct packed {
        logic        receive_poll;
        logic        transmit_kick;
        logic [31:0] read_data;
    } vnet_result_t;

endpackage

// ===== src/virtio_net_mmio_register_block.sv =====
// ----------------------------------------------------------------------------
// virtio_net_mmio_register_block
// Register file of a virtio-mmio (version 2) network device.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis carries one bus operation per word: tuser holds the
//   operation (read, write, used-ring posted), tdata the register offset and
//   the write value. Master stream m_axis returns one word per operation:
//   the read value and the transmit kick / receive poll pulses.
//   The MAC address is loaded through cfg_wr_en / cfg_wr_data while idle.
// Timing:
//   Decode, register update and read mux are combinational between the slave
//   handshake and the output register (the skid register while the output
//   stalls), and one word is taken every cycle while s_axis_tready is high.
// Stall:
//   A two-entry output buffer (output register plus skid register) lets the
//   block take a word while the previous result is still held; s_axis_tready
//   drops only when both entries are full.
// Reset:
//   rst_n clears all device registers and the output buffer and reloads the
//   default MAC. A status write of zero clears the device registers again
//   but keeps the MAC.
// ----------------------------------------------------------------------------
module virtio_net_mmio_register_block #(
    parameter int QUEUE_SIZE_MAX = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // MAC address load
    input  logic                                cfg_wr_en,
    input  logic [vnet_mmio_pkg::MAC_W-1:0]     cfg_wr_data,
    // operation words
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [vnet_mmio_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // register_offset, write_data
    input  logic [1:0]                          s_axis_tuser,  // operation
    // result words
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [vnet_mmio_pkg::OUT_TDATA_W-1:0] m_axis_tdata  // read_data, transmit_kick,
                                                                // receive_poll
);
    import vnet_mmio_pkg::*;

    localparam int QSIZE_W = $clog2(QUEUE_SIZE_MAX + 1);

    // Device registers
    logic [31:0]                    queue_select_reg;
    logic [31:0]                    dev_feat_sel_reg;
    logic                           drv_feat_sel_reg;
    logic [1:0][31:0]               drv_features_reg;
    logic [31:0]                    device_status_reg;
    logic [31:0]                    int_status_reg;
    logic [1:0][QSIZE_W-1:0]        queue_size_reg;
    logic [1:0]                     queue_ready_reg;
    logic [1:0][15:0]               last_avail_reg;
    logic [1:0][63:0]               desc_addr_reg;
    logic [1:0][63:0]               avail_addr_reg;
    logic [1:0][63:0]               used_addr_reg;
    logic [MAC_W-1:0]               mac_reg;

    // Output buffer
    vnet_result_t                   out_reg;
    vnet_result_t                   skid_reg;
    logic                           out_valid_reg;
    logic                           skid_valid_reg;
    vnet_result_t                   res_next;

    logic [1:0]                     in_op;
    logic [OFFSET_W-1:0]            in_off;
    logic [DATA_W-1:0]              in_val;
    logic                           in_acc;
    logic                           out_acc;
    logic                           q_sel;
    logic                           q_valid;

    assign in_op   = s_axis_tuser;
    assign in_off  = s_axis_tdata[OFFSET_W-1:0];
    assign in_val  = s_axis_tdata[OFFSET_W+DATA_W-1:OFFSET_W];
    assign s_axis_tready = !skid_valid_reg;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = out_valid_reg && m_axis_tready;

    assign q_sel   = queue_select_reg[0];
    assign q_valid = (queue_select_reg[31:1] == 31'd0);

    // Result of the current word: read mux and notify pulses
    always_comb
    begin
        res_next = '0;
        if (in_op == OP_READ)
        begin
            case (in_off)
                REG_MAGIC:         res_next.read_data = MAGIC_VALUE;
                REG_VERSION:       res_next.read_data = VERSION_VALUE;
                REG_DEVICE_ID:     res_next.read_data = DEVICE_ID_NET;
                REG_VENDOR_ID:     res_next.read_data = VENDOR_VALUE;
                REG_DEV_FEATURES:
                begin
                    if (dev_feat_sel_reg == 32'd0)
                        res_next.read_data = FEAT_WORD0;
                    else if (dev_feat_sel_reg == 32'd1)
                        res_next.read_data = FEAT_WORD1;
                end
                REG_QUEUE_NUM_MAX:
                    if (q_valid)
                        res_next.read_data = 32'(QUEUE_SIZE_MAX);
                REG_QUEUE_READY:
                    if (q_valid)
                        res_next.read_data = {31'd0, queue_ready_reg[q_sel]};
                REG_INT_STATUS:    res_next.read_data = int_status_reg;
                REG_STATUS:        res_next.read_data = device_status_reg;
                default:
                begin
                    // config space: MAC bytes as little-endian words
                    if (in_off >= REG_CFG_MAC_FIRST && in_off < REG_CFG_MAC_END)
                    begin
                        if (in_off[2])
                            res_next.read_data = {16'd0, mac_reg[47:32]};
                        else
                            res_next.read_data = mac_reg[31:0];
                    end
                end
            endcase
        end
        else if (in_op == OP_WRITE && in_off == REG_QUEUE_NOTIFY)
        begin
            res_next.transmit_kick = (in_val == 32'd1);
            res_next.receive_poll  = (in_val == 32'd0)
                                     && device_status_reg[STATUS_DRV_OK_BIT]
                                     && queue_ready_reg[0];
        end
    end

    // Register updates for writes, used-ring events and MAC loads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_reg           <= MAC_RESET;
            queue_select_reg  <= '0;
            dev_feat_sel_reg  <= '0;
            drv_feat_sel_reg  <= 1'b0;
            drv_features_reg  <= '0;
            device_status_reg <= '0;
            int_status_reg    <= '0;
            queue_size_reg    <= '0;
            queue_ready_reg   <= '0;
            last_avail_reg    <= '0;
            desc_addr_reg     <= '0;
            avail_addr_reg    <= '0;
            used_addr_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                mac_reg <= cfg_wr_data;
            if (in_acc)
            begin
                case (in_op)
                    OP_WRITE:
                    begin
                        case (in_off)
                            REG_DEV_FEAT_SEL: dev_feat_sel_reg <= in_val;
                            REG_DRV_FEATURES: drv_features_reg[drv_feat_sel_reg] <= in_val;
                            REG_DRV_FEAT_SEL: drv_feat_sel_reg <= in_val[0];
                            REG_QUEUE_SEL:    queue_select_reg <= in_val;
                            REG_QUEUE_NUM:
                                if (q_valid)
                                begin
                                    // clamp to the size limit
                                    if (in_val > 32'(QUEUE_SIZE_MAX))
                                        queue_size_reg[q_sel] <= QSIZE_W'(QUEUE_SIZE_MAX);
                                    else
                                        queue_size_reg[q_sel] <= in_val[QSIZE_W-1:0];
                                end
                            REG_QUEUE_READY:
                                if (q_valid)
                                begin
                                    queue_ready_reg[q_sel] <= in_val[0];
                                    if (in_val[0])
                                        last_avail_reg[q_sel] <= '0;
                                end
                            REG_INT_ACK:      int_status_reg <= int_status_reg & ~in_val;
                            REG_STATUS:
                                if (in_val == 32'd0)
                                begin
                                    // device reset, MAC kept
                                    queue_select_reg  <= '0;
                                    dev_feat_sel_reg  <= '0;
                                    drv_feat_sel_reg  <= 1'b0;
                                    drv_features_reg  <= '0;
                                    device_status_reg <= '0;
                                    int_status_reg    <= '0;
                                    queue_size_reg    <= '0;
                                    queue_ready_reg   <= '0;
                                    last_avail_reg    <= '0;
                                    desc_addr_reg     <= '0;
                                    avail_addr_reg    <= '0;
                                    used_addr_reg     <= '0;
                                end
                                else
                                    device_status_reg <= in_val;
                            REG_DESC_LOW:   desc_addr_reg[q_sel][31:0]   <= in_val;
                            REG_DESC_HIGH:  desc_addr_reg[q_sel][63:32]  <= in_val;
                            REG_AVAIL_LOW:  avail_addr_reg[q_sel][31:0]  <= in_val;
                            REG_AVAIL_HIGH: avail_addr_reg[q_sel][63:32] <= in_val;
                            REG_USED_LOW:   used_addr_reg[q_sel][31:0]   <= in_val;
                            REG_USED_HIGH:  used_addr_reg[q_sel][63:32]  <= in_val;
                            default: ;
                        endcase
                    end
                    OP_USED:  int_status_reg[0] <= 1'b1;
                    default: ;
                endcase
            end
        end
    end

    // Output register and skid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                if (!out_valid_reg || out_acc)
                    out_valid_reg <= 1'b1;
                else
                    skid_valid_reg <= 1'b1;
            end
            else if (out_acc)
            begin
                if (skid_valid_reg)
                    skid_valid_reg <= 1'b0;
                else
                    out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the output buffer
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            if (!out_valid_reg || out_acc)
                out_reg <= res_next;
            else
                skid_reg <= res_next;
        end
        else if (out_acc && skid_valid_reg)
            out_reg <= skid_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(vnet_result_t)){1'b0}}, out_reg};

endmodule

// ===== src/vnet_mmio_checker.sv =====
// ----------------------------------------------------------------------------
// vnet_mmio_checker
// Port-level checks of the register block's result stream.
// ----------------------------------------------------------------------------
module vnet_mmio_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic [vnet_mmio_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input logic [1:0]                           s_axis_tuser,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [vnet_mmio_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import vnet_mmio_pkg::*;

    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // backpressure only from a full output buffer
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("tready low with empty output");

    // word taken into an empty buffer shows up in the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && !m_axis_tvalid |=> m_axis_tvalid)
        else $error("result missing one cycle after accept");

    // magic read goes straight to the output register
    a_magic: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && !m_axis_tvalid && s_axis_tuser == OP_READ
        && s_axis_tdata[OFFSET_W-1:0] == REG_MAGIC
        |=> m_axis_tdata[DATA_W-1:0] == MAGIC_VALUE)
        else $error("wrong magic value");

    // kick and poll exclusive
    a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[32] && m_axis_tdata[33]))
        else $error("transmit kick and receive poll together");

endmodule

bind virtio_net_mmio_register_block vnet_mmio_checker u_vnet_mmio_checker (.*);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stream-level bench for the virtio-mmio network device register block.
// A directed pass walks the identity, feature, queue, notify, interrupt and
// status registers plus the MAC config window. Several random phases follow,
// each under a different MAC setting. A local model of the register file
// predicts every result word, and results are checked in order as they
// leave the block. Both streams idle at random, except in one calm phase.
// ----------------------------------------------------------------------------
module tb_top;
    import vnet_mmio_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          QSIZE_LIMIT    = 256;
    localparam int          STALL_LIMIT    = 2000;
    localparam int          MAX_REPORTS    = 10;
    localparam int          IDLE_PCT       = 15;
    localparam int          PHASE_ITEMS    = 200;
    localparam int          NUM_PHASES     = 5;
    localparam int          CALM_PHASE     = 2;
    localparam int          NUM_MAPPED     = 30;
    localparam logic [1:0]  OP_RESERVED    = 2'd3;
    localparam logic [11:0] REG_CONFIG_GEN = 12'h0fc;
    localparam logic [11:0] OFF_UNMAPPED   = 12'hfff;
    localparam logic [31:0] DRV_OK_MASK    = 32'd1 << STATUS_DRV_OK_BIT;

    // one bus operation as it goes out on the slave stream
    typedef struct packed {
        logic [1:0]        op;
        logic [OFFSET_W-1:0] offset;
        logic [DATA_W-1:0] wdata;
    } bus_op_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [MAC_W-1:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = OP_READ;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    bus_op_t      op_backlog[$];
    vnet_result_t awaited_results[$];
    bus_op_t      next_op;
    logic         calm = 1'b0;
    logic [11:0]  reg_map [0:NUM_MAPPED-1];

    // register file copy; only state that can reach a result word is kept
    logic [MAC_W-1:0]  m_mac;
    logic [31:0]       m_queue_sel;
    logic [31:0]       m_feat_sel;
    logic [31:0]       m_status;
    logic [31:0]       m_irq;
    logic              m_q_ready [0:1];

    int errors = 0;
    int checked = 0;
    int n_reads = 0;
    int n_writes = 0;
    int n_events = 0;
    int n_kicks = 0;
    int n_polls = 0;
    int stall_cycles = 0;

    virtio_net_mmio_register_block #(
        .QUEUE_SIZE_MAX (QSIZE_LIMIT)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),     // register_offset, write_data
        .s_axis_tuser  (s_tuser),     // operation
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)      // read_data, transmit_kick, receive_poll
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void clear_device_model();
        m_queue_sel = '0;
        m_feat_sel  = '0;
        m_status    = '0;
        m_irq       = '0;
        m_q_ready[0] = 1'b0;
        m_q_ready[1] = 1'b0;
    endfunction

    // apply one bus operation to the model and return its result word
    function automatic vnet_result_t mmio_access(logic [1:0] op, logic [11:0] off,
                                                 logic [31:0] val);
        vnet_result_t r;
        logic         q_ok;
        r = '0;
        q_ok = (m_queue_sel < 32'd2);
        if (op == OP_READ)
        begin
            n_reads++;
            case (off)
                REG_MAGIC:         r.read_data = MAGIC_VALUE;
                REG_VERSION:       r.read_data = VERSION_VALUE;
                REG_DEVICE_ID:     r.read_data = DEVICE_ID_NET;
                REG_VENDOR_ID:     r.read_data = VENDOR_VALUE;
                REG_DEV_FEATURES:
                    r.read_data = (m_feat_sel == 32'd0) ? FEAT_WORD0 :
                                  (m_feat_sel == 32'd1) ? FEAT_WORD1 : 32'd0;
                REG_QUEUE_NUM_MAX: r.read_data = q_ok ? 32'(QSIZE_LIMIT) : 32'd0;
                REG_QUEUE_READY:   r.read_data = q_ok ? 32'(m_q_ready[m_queue_sel[0]]) : 32'd0;
                REG_INT_STATUS:    r.read_data = m_irq;
                REG_STATUS:        r.read_data = m_status;
                default:
                    // MAC window: first word bytes 0..3, second word bytes 4..5
                    if (off >= REG_CFG_MAC_FIRST && off < REG_CFG_MAC_END)
                        r.read_data = off[2] ? {16'd0, m_mac[47:32]} : m_mac[31:0];
            endcase
        end
        else if (op == OP_WRITE)
        begin
            n_writes++;
            case (off)
                REG_DEV_FEAT_SEL: m_feat_sel = val;
                REG_QUEUE_SEL:    m_queue_sel = val;
                REG_QUEUE_READY:
                    if (q_ok)
                        m_q_ready[m_queue_sel[0]] = val[0];
                REG_QUEUE_NOTIFY:
                    if (val == 32'd1)
                        r.transmit_kick = 1'b1;
                    else if (val == 32'd0 && m_status[STATUS_DRV_OK_BIT] && m_q_ready[0])
                        r.receive_poll = 1'b1;
                REG_INT_ACK:      m_irq = m_irq & ~val;
                REG_STATUS:
                    if (val == 32'd0)
                        clear_device_model();
                    else
                        m_status = val;
                default: ;
            endcase
        end
        else if (op == OP_USED)
        begin
            n_events++;
            m_irq[0] = 1'b1;
        end
        n_kicks += r.transmit_kick;
        n_polls += r.receive_poll;
        return r;
    endfunction

    // slave side driver, fed from the backlog
    always @(posedge clk)
    begin
        if (!s_tvalid || s_tready)
        begin
            if (rst_n && op_backlog.size() != 0 &&
                (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                next_op = op_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_op.op;
                s_tdata  <= {{(IN_TDATA_W - OFFSET_W - DATA_W){1'b0}},
                             next_op.wdata, next_op.offset};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // master side ready
    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // prediction on each accepted word and each MAC load
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                m_mac = cfg_wr_data;
            if (s_tvalid && s_tready)
                awaited_results.insert(awaited_results.size(),
                                       mmio_access(s_tuser, s_tdata[OFFSET_W-1:0],
                                                   s_tdata[OFFSET_W +: DATA_W]));
        end
    end

    // result checker
    always @(posedge clk)
    begin
        vnet_result_t got;
        vnet_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(vnet_result_t)-1:0];
            if (awaited_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result word: data %h kick %b poll %b",
                             got.read_data, got.transmit_kick, got.receive_poll);
            end
            else
            begin
                want = awaited_results.pop_front();
                checked++;
                if (got.read_data !== want.read_data ||
                    got.transmit_kick !== want.transmit_kick ||
                    got.receive_poll !== want.receive_poll)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("mismatch on word %0d: expected data %h kick %b poll %b, got data %h kick %b poll %b",
                                 checked, want.read_data, want.transmit_kick,
                                 want.receive_poll, got.read_data, got.transmit_kick,
                                 got.receive_poll);
                end
            end
        end
    end

    // watchdog: cycles with work outstanding but no handshake
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (op_backlog.size() == 0 && awaited_results.size() == 0 && !s_tvalid))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic queue_op(logic [1:0] op, logic [11:0] off, logic [31:0] val);
        bus_op_t item;
        item = '{op: op, offset: off, wdata: val};
        op_backlog.insert(op_backlog.size(), item);
    endtask

    // block until all words are out and answered, then let the pipe settle
    task automatic drain();
        while (op_backlog.size() != 0 || s_tvalid || awaited_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic load_mac(logic [MAC_W-1:0] mac);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mac;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int          k;
        int          phase;
        bus_op_t     w;
        logic [47:0] mac_val;

        reg_map = '{REG_MAGIC, REG_VERSION, REG_DEVICE_ID, REG_VENDOR_ID,
                    REG_DEV_FEATURES, REG_DEV_FEAT_SEL, REG_DRV_FEATURES,
                    REG_DRV_FEAT_SEL, REG_QUEUE_SEL, REG_QUEUE_NUM_MAX,
                    REG_QUEUE_NUM, REG_QUEUE_READY, REG_QUEUE_NOTIFY,
                    REG_INT_STATUS, REG_INT_ACK, REG_STATUS, REG_DESC_LOW,
                    REG_DESC_HIGH, REG_AVAIL_LOW, REG_AVAIL_HIGH, REG_USED_LOW,
                    REG_USED_HIGH, REG_CONFIG_GEN, REG_CFG_MAC_FIRST,
                    REG_CFG_MAC_FIRST + 12'd1, REG_CFG_MAC_FIRST + 12'd2,
                    REG_CFG_MAC_FIRST + 12'd3, REG_CFG_MAC_FIRST + 12'd4,
                    REG_CFG_MAC_FIRST + 12'd5, REG_CFG_MAC_END};
        m_mac = MAC_RESET;
        clear_device_model();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: identity, features, MAC window with the default MAC
        queue_op(OP_READ, REG_MAGIC, '0);
        queue_op(OP_READ, REG_VERSION, '0);
        queue_op(OP_READ, REG_DEVICE_ID, '0);
        queue_op(OP_READ, REG_VENDOR_ID, '0);
        queue_op(OP_READ, REG_DEV_FEATURES, '0);
        queue_op(OP_WRITE, REG_DEV_FEAT_SEL, 32'd1);
        queue_op(OP_READ, REG_DEV_FEATURES, '0);
        queue_op(OP_WRITE, REG_DEV_FEAT_SEL, '1);
        queue_op(OP_READ, REG_DEV_FEATURES, '0);
        queue_op(OP_READ, REG_CFG_MAC_FIRST, '0);
        queue_op(OP_READ, REG_CFG_MAC_FIRST + 12'd4, '0);
        queue_op(OP_READ, REG_CFG_MAC_END, '0);
        queue_op(OP_READ, OFF_UNMAPPED, '0);
        // queue 0 ready, driver ready status, then the notify variants
        queue_op(OP_WRITE, REG_QUEUE_NUM, '1);
        queue_op(OP_WRITE, REG_QUEUE_READY, 32'd1);
        queue_op(OP_WRITE, REG_STATUS, DRV_OK_MASK);
        queue_op(OP_WRITE, REG_QUEUE_NOTIFY, 32'd0);
        queue_op(OP_WRITE, REG_QUEUE_NOTIFY, 32'd1);
        queue_op(OP_WRITE, REG_QUEUE_NOTIFY, '1);
        // used-ring event, then acknowledge it
        queue_op(OP_USED, OFF_UNMAPPED, '1);
        queue_op(OP_READ, REG_INT_STATUS, '0);
        queue_op(OP_WRITE, REG_INT_ACK, '1);
        // queue beyond the second one, reserved op, unmapped write
        queue_op(OP_WRITE, REG_QUEUE_SEL, '1);
        queue_op(OP_READ, REG_QUEUE_NUM_MAX, '0);
        queue_op(OP_RESERVED, REG_STATUS, '1);
        queue_op(OP_WRITE, OFF_UNMAPPED, '1);
        // status zero resets the device registers
        queue_op(OP_WRITE, REG_STATUS, '0);
        queue_op(OP_READ, REG_QUEUE_READY, '0);
        drain();

        // random phases, each behind a fresh MAC
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:       mac_val = '0;
                1:       mac_val = '1;
                default: mac_val = 48'({$urandom, $urandom});
            endcase
            load_mac(mac_val);
            calm = (phase == CALM_PHASE);
            repeat (PHASE_ITEMS)
            begin
                k = $urandom_range(99);
                w.op = (k < 4) ? OP_RESERVED : (k < 12) ? OP_USED :
                       (k < 55) ? OP_READ : OP_WRITE;
                w.offset = ($urandom_range(99) < 10) ? 12'($urandom)
                                                     : reg_map[$urandom_range(NUM_MAPPED - 1)];
                case (w.offset)
                    REG_QUEUE_SEL, REG_DEV_FEAT_SEL:
                        w.wdata = ($urandom_range(9) == 0) ? $urandom : $urandom_range(3);
                    REG_QUEUE_NOTIFY:
                        w.wdata = ($urandom_range(4) == 0) ? $urandom : $urandom_range(1);
                    REG_STATUS:
                        w.wdata = ($urandom_range(99) < 8) ? 32'd0 :
                                  ($urandom | (($urandom_range(9) < 7) ? DRV_OK_MASK : 32'd0));
                    default:
                        w.wdata = $urandom;
                endcase
                op_backlog.insert(op_backlog.size(), w);
            end
            drain();
            calm = 1'b0;
        end

        errors += awaited_results.size();
        $display("covered %0d reads, %0d writes, %0d used-ring events over %0d MAC settings",
                 n_reads, n_writes, n_events, NUM_PHASES + 1);
        $display("checked %0d result words, %0d transmit kicks, %0d receive polls",
                 checked, n_kicks, n_polls);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/vnet_mmio_pkg.sv
src/virtio_net_mmio_register_block.sv
src/vnet_mmio_checker.sv
bench/tb_top.sv
